>>> rtl/world_to_screen_projection_defines.svh
// ----------------------------------------------------------------------------
// World-to-screen projection assertion macros
// Shared concurrent assertion forms for the projection block.
// ----------------------------------------------------------------------------
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// same-cycle implication
`define WTSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define WTSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/wtsp_pkg.sv
// ----------------------------------------------------------------------------
// World-to-screen projection package
// Widths, register indexes and item types shared by the projection modules.
// ----------------------------------------------------------------------------
package wtsp_pkg;

   localparam int DATA_W  = 32;
   localparam int PROD_W  = 2 * DATA_W;
   localparam int C_W     = PROD_W + 3;     // clip value width
   localparam int W_W     = C_W - 1;        // positive clip w width
   localparam int HALF_W  = 13;
   localparam int CSR_W   = 14;
   localparam int Q_BITS  = 18;             // quotient bits kept
   localparam int D_W     = W_W + Q_BITS;   // divider datapath width
   localparam int REQ_W   = 136;
   localparam int RSP_W   = 32;
   localparam int Q_DEPTH = 4;
   localparam int Q_AW    = 2;
   localparam int Q_CW    = 3;

   typedef enum logic [0:0] {
      CSR_WIDTH  = 1'b0,
      CSR_HEIGHT = 1'b1
   } csr_idx_type;

   typedef struct packed {
      logic                     is_point;
      logic [3:0]               idx;
      logic signed [DATA_W-1:0] val;
      logic signed [DATA_W-1:0] x;
      logic signed [DATA_W-1:0] y;
      logic signed [DATA_W-1:0] z;
   } item_type;

   typedef struct packed {
      logic [Q_CW-1:0] count;
      logic            full;
   } fe_stat_type;

   typedef struct packed {
      logic                vld;
      logic signed [C_W-1:0] cx;
      logic signed [C_W-1:0] cy;
      logic signed [C_W-1:0] cw;
   } clip_type;

   typedef struct packed {
      logic              vld;
      logic              vis;
      logic              sx;
      logic              sy;
      logic [HALF_W-1:0] hw;
      logic [HALF_W-1:0] hh;
      logic [D_W-1:0]    rx;
      logic [D_W-1:0]    ry;
      logic [W_W-1:0]    w;
      logic              ovx;
      logic              ovy;
      logic [Q_BITS-1:0] qx;
      logic [Q_BITS-1:0] qy;
   } dv_type;

endpackage

>>> rtl/wtsp_front.sv
// ----------------------------------------------------------------------------
// Projection front end
// Accepts items, classifies matrix loads and points, and queues them.
// ----------------------------------------------------------------------------
module wtsp_front
   import wtsp_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             pop,
   output item_type         head,
   output logic             head_vld,
   output fe_stat_type      stat
);

   item_type        q_mem [Q_DEPTH];
   logic [Q_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_CW-1:0] cnt_ff, cnt_in;
   logic            push;
   item_type        item;

   always_comb begin
      item.is_point = req_tuser;
      item.idx      = req_tdata[3:0];
      item.val      = req_tdata[35:4];
      item.x        = req_tdata[67:36];
      item.y        = req_tdata[99:68];
      item.z        = req_tdata[131:100];
   end

   assign req_tready = (cnt_ff != Q_CW'(Q_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign head_vld   = (cnt_ff != '0);
   assign head       = q_mem[rd_ptr_ff];
   assign stat.count = cnt_ff;
   assign stat.full  = !req_tready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + Q_CW'(push) - Q_CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= item;
      end
   end

endmodule

>>> rtl/wtsp_clip.sv
// ----------------------------------------------------------------------------
// Projection clip stage
// Holds the view matrix and forms clip x, y and w for each point.
// ----------------------------------------------------------------------------
module wtsp_clip
   import wtsp_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic     clock,
   input  logic     reset,
   input  logic     en,
   input  logic     in_vld,
   input  item_type in_item,
   output clip_type clip
);

   localparam logic [1:0] ROW_SEL [3] = '{2'd0, 2'd1, 2'd3};

   logic signed [DATA_W-1:0] mat_ff [16];
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [DATA_W-1:0] m3_ff [3];
   logic                     pv_ff;
   logic signed [C_W-1:0]    cval [3];
   logic signed [C_W-2:0]    psum;
   clip_type                 clip_ff, clip_in;
   logic signed [DATA_W-1:0] coord [3];

   assign coord[0] = in_item.x;
   assign coord[1] = in_item.y;
   assign coord[2] = in_item.z;

   // matrix loads take effect in queue order, ahead of later points
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) begin
            mat_ff[i] <= '0;
         end
      end else if (en && in_vld && !in_item.is_point) begin
         mat_ff[in_item.idx] <= in_item.val;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= mat_ff[{ROW_SEL[r], 2'(c)}] * coord[c];
            end
            m3_ff[r] <= mat_ff[{ROW_SEL[r], 2'd3}];
         end
      end
   end

   always_comb begin
      psum = '0;
      for (int r = 0; r < 3; r++) begin
         psum    = (C_W-1)'(prod_ff[r][0]) + (C_W-1)'(prod_ff[r][1])
                 + (C_W-1)'(prod_ff[r][2]);
         cval[r] = C_W'(psum >>> FRAC_BITS) + C_W'(m3_ff[r]);
      end
      clip_in.vld = pv_ff;
      clip_in.cx  = cval[0];
      clip_in.cy  = cval[1];
      clip_in.cw  = cval[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pv_ff       <= 1'b0;
         clip_ff.vld <= 1'b0;
      end else if (en) begin
         pv_ff   <= in_vld && in_item.is_point;
         clip_ff <= clip_in;
      end
   end

   assign clip = clip_ff;

endmodule

>>> rtl/wtsp_div.sv
// ----------------------------------------------------------------------------
// Projection divide and viewport stage
// Scales clip x and y by half the viewport over w, one quotient bit a stage.
// ----------------------------------------------------------------------------
module wtsp_div
   import wtsp_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                en,
   input  clip_type            clip,
   input  logic [HALF_W-1:0]   hw,
   input  logic [HALF_W-1:0]   hh,
   output logic                out_vld,
   output logic                out_vis,
   output logic signed [15:0]  out_x,
   output logic signed [15:0]  out_y
);

   localparam int                    NST    = Q_BITS + 3;
   localparam logic signed [C_W-1:0] THRESH = C_W'(((64'sd1 <<< FRAC_BITS) + 5) / 10);
   localparam logic signed [20:0]    SMAX   = 21'sd32767;
   localparam logic signed [20:0]    SMIN   = -21'sd32768;

   dv_type                    st_ff [NST];
   dv_type                    st_in [NST];
   logic [HALF_W+C_W-1:0]     npx, npy;
   logic [D_W-1:0]            wsh;
   logic [Q_BITS-1:0]         qx_e, qy_e;
   logic signed [20:0]        hws, hhs, qxs, qys, vx, vy;
   logic                      ovld_ff, ovis_ff;
   logic signed [15:0]        ox_ff, oy_ff, ox_in, oy_in;

   always_comb begin
      // take magnitudes and the visibility test
      st_in[0]     = '0;
      st_in[0].vld = clip.vld;
      st_in[0].vis = (clip.cw >= THRESH);
      st_in[0].sx  = clip.cx[C_W-1];
      st_in[0].sy  = clip.cy[C_W-1];
      st_in[0].hw  = hw;
      st_in[0].hh  = hh;
      st_in[0].rx  = D_W'(clip.cx[C_W-1] ? C_W'(-clip.cx) : C_W'(clip.cx));
      st_in[0].ry  = D_W'(clip.cy[C_W-1] ? C_W'(-clip.cy) : C_W'(clip.cy));
      st_in[0].w   = clip.cw[W_W-1:0];

      // scale by half the viewport
      st_in[1]    = st_ff[0];
      npx         = st_ff[0].hw * st_ff[0].rx[C_W-1:0];
      npy         = st_ff[0].hh * st_ff[0].ry[C_W-1:0];
      st_in[1].rx = D_W'(npx);
      st_in[1].ry = D_W'(npy);

      // flag quotients that do not fit
      st_in[2]     = st_ff[1];
      wsh          = D_W'(st_ff[1].w) << Q_BITS;
      st_in[2].ovx = (st_ff[1].rx >= wsh);
      st_in[2].ovy = (st_ff[1].ry >= wsh);

      // restoring division, most significant bit first
      for (int k = 3; k < NST; k++) begin
         st_in[k] = st_ff[k-1];
         wsh      = D_W'(st_ff[k-1].w) << (NST - 1 - k);
         if (st_ff[k-1].rx >= wsh) begin
            st_in[k].rx              = st_ff[k-1].rx - wsh;
            st_in[k].qx[NST - 1 - k] = 1'b1;
         end
         if (st_ff[k-1].ry >= wsh) begin
            st_in[k].ry              = st_ff[k-1].ry - wsh;
            st_in[k].qy[NST - 1 - k] = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NST; k++) begin
            st_ff[k].vld <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < NST; k++) begin
            st_ff[k] <= st_in[k];
         end
      end
   end

   always_comb begin
      qx_e = st_ff[NST-1].ovx ? '1 : st_ff[NST-1].qx;
      qy_e = st_ff[NST-1].ovy ? '1 : st_ff[NST-1].qy;
      hws  = signed'(21'(st_ff[NST-1].hw));
      hhs  = signed'(21'(st_ff[NST-1].hh));
      qxs  = signed'(21'(qx_e));
      qys  = signed'(21'(qy_e));
      vx   = st_ff[NST-1].sx ? hws - qxs : hws + qxs;
      vy   = st_ff[NST-1].sy ? hhs + qys : hhs - qys;
      priority if (vx > SMAX) ox_in = 16'sh7FFF;
      else if (vx < SMIN)     ox_in = -16'sh8000;
      else                    ox_in = vx[15:0];
      priority if (vy > SMAX) oy_in = 16'sh7FFF;
      else if (vy < SMIN)     oy_in = -16'sh8000;
      else                    oy_in = vy[15:0];
      // zero the coordinates of points that fail the visibility test
      if (!st_ff[NST-1].vis) begin
         ox_in = '0;
         oy_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (en) begin
         ovld_ff <= st_ff[NST-1].vld;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ovis_ff <= st_ff[NST-1].vis;
         ox_ff   <= ox_in;
         oy_ff   <= oy_in;
      end
   end

   assign out_vld = ovld_ff;
   assign out_vis = ovis_ff;
   assign out_x   = ox_ff;
   assign out_y   = oy_ff;

endmodule

>>> rtl/world_to_screen_projection.sv
// ----------------------------------------------------------------------------
// World-to-screen projection
// Projects fixed-point world points to saturated screen pixel coordinates.
// ----------------------------------------------------------------------------
// Input items arrive on req_*: tuser is the mode. Mode 0 loads one entry of
// the 4x4 view-projection matrix and yields nothing; mode 1 carries a point
// and yields one result on rsp_*: tuser is the visible flag, tdata holds the
// screen x and y. Viewport width and height are set through csr_*; the user
// must set them only while the block is idle; the block does not enforce it.
// Throughput: one item per cycle unless a waiting result is held by rsp_tready.
// Between acceptance and a result lie the products, clip sums, magnitudes,
// viewport scale, fit check, 18 restoring divide stages and the output
// register. The one-bit-per-stage divider sets the depth.
// A four-entry queue parts the front end from the back pipeline, so items
// are accepted while a result waits. When rsp_tready is low with a result
// pending the whole back pipeline holds; the queue fills, then req_tready falls.
// Reset clears the matrix to zero, sets the viewport to 1920 by 1080 and
// empties the queue and pipeline.
// ----------------------------------------------------------------------------
`include "world_to_screen_projection_defines.svh"

module world_to_screen_projection
   import wtsp_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic             req_tuser,   // mode
   input  logic [REQ_W-1:0] req_tdata,   // matrix_index, matrix_value, pos_x, pos_y, pos_z
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic             rsp_tuser,   // visible
   output logic [RSP_W-1:0] rsp_tdata,   // screen_x, screen_y
   input  logic             csr_we,
   input  logic [0:0]       csr_addr,
   input  logic [CSR_W-1:0] csr_wdata
);

   logic [CSR_W-1:0] width_ff, height_ff;
   logic             back_en, pop, head_vld;
   item_type         head;
   fe_stat_type      fe_stat;
   clip_type         clip;
   logic signed [15:0] sx, sy;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= CSR_W'(1920);
         height_ff <= CSR_W'(1080);
      end else if (csr_we) begin
         unique case (csr_idx_type'(csr_addr))
            CSR_WIDTH:  width_ff  <= csr_wdata;
            CSR_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign back_en = !rsp_tvalid || rsp_tready;
   assign pop     = back_en && head_vld;

   wtsp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .pop        (pop),
      .head       (head),
      .head_vld   (head_vld),
      .stat       (fe_stat)
   );

   wtsp_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
      .clock   (clock),
      .reset   (reset),
      .en      (back_en),
      .in_vld  (pop),
      .in_item (head),
      .clip    (clip)
   );

   wtsp_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (back_en),
      .clip    (clip),
      .hw      (width_ff[CSR_W-1:1]),
      .hh      (height_ff[CSR_W-1:1]),
      .out_vld (rsp_tvalid),
      .out_vis (rsp_tuser),
      .out_x   (sx),
      .out_y   (sy)
   );

   assign rsp_tdata = {sy, sx};

   `WTSP_ASSERT_IMP(a_hidden_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata == '0, "hidden point has nonzero coordinates")
   `WTSP_ASSERT_NXT(a_stall_no_pop, clock, reset, !back_en, fe_stat.count >= $past(fe_stat.count), "queue drained while back end stalled")
   `WTSP_ASSERT_IMP(a_full_blocks, clock, reset, fe_stat.full, !req_tready && head_vld, "full queue still ready")

endmodule
